@@ sv/tkcs_pkg.sv @@
`timescale 1ns / 1ps

package tkcs_pkg;

  // List depth and field widths
  localparam int TOP_K        = 10;
  localparam int COUNT_BITS   = 31;
  localparam int WORD_ID_BITS = 20;
  localparam int RANK_BITS    = 4;

  // Index of a slot; one bit at least so a one-deep list still has a counter
  localparam int IDX_BITS = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  // Packed beat widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((COUNT_BITS + WORD_ID_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((RANK_BITS + COUNT_BITS + WORD_ID_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                    valid;
    logic [COUNT_BITS-1:0]   count;
    logic [WORD_ID_BITS-1:0] word_id;
  } slot_t;

  typedef slot_t [TOP_K-1:0] slot_list_t;

endpackage

@@ sv/tkcs_insert.sv @@
`timescale 1ns / 1ps

// One insertion step over the whole list: parallel compares and a one-place shift.
module tkcs_insert (
  input  tkcs_pkg::slot_list_t                  list_cur,
  input  logic [tkcs_pkg::COUNT_BITS-1:0]       entry_count,
  input  logic [tkcs_pkg::WORD_ID_BITS-1:0]     word_id,
  output tkcs_pkg::slot_list_t                  list_next
);

  // ge[i]: slot i stays ahead of the new entry (ties keep the older entry first).
  // Valid slots are a sorted prefix, so ge is a run of ones from rank 0.
  logic [tkcs_pkg::TOP_K-1:0] ge;
  tkcs_pkg::slot_t            new_slot;

  assign new_slot = '{valid: 1'b1, count: entry_count, word_id: word_id};

  always_comb begin
    for (int i = 0; i < tkcs_pkg::TOP_K; i++) begin
      ge[i] = list_cur[i].valid && (list_cur[i].count >= entry_count);
    end
  end

  always_comb begin
    for (int i = 0; i < tkcs_pkg::TOP_K; i++) begin
      if (ge[i]) begin
        list_next[i] = list_cur[i];
      end else if (i == 0) begin
        list_next[i] = new_slot;
      end else if (ge[i-1]) begin
        list_next[i] = new_slot;
      end else begin
        list_next[i] = list_cur[i-1];
      end
    end
  end

endmodule

@@ sv/top_k_count_selector.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Fields (tdata from bit 0 up)                   Side bits
// s_*       in   entry_count[30:0], word_id[50:31], pad to 56    tlast = last_entry
// m_*       out  rank[3:0], kept_count[34:4], kept_word_id[54:35] tuser = slot_valid,
//                pad to 56                                       tlast = last_result
//
// One entry per cycle is taken unless a last-marked entry is held back; each entry passes
// through the input register and is folded into the list by a single compare-and-shift pass.
// An entry marked last loads the finished list into a shift-out buffer and clears the
// list; the buffer then drives TOP_K beats, one per cycle while m_tready is high.
// Entries keep flowing during that drain; only a further last-marked entry waits in
// the input register until the drain's final beat is taken.
// rst is synchronous and active high: list empty, no beat pending.
module top_k_count_selector (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [tkcs_pkg::IN_DATA_BITS-1:0]     s_tdata,   // entry_count, word_id
  input  logic                                  s_tlast,   // last_entry
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [tkcs_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // rank, kept_count, kept_word_id
  output logic                                  m_tuser,   // slot_valid
  output logic                                  m_tlast    // last_result
);

  localparam int CB = tkcs_pkg::COUNT_BITS;
  localparam int WB = tkcs_pkg::WORD_ID_BITS;
  localparam int RB = tkcs_pkg::RANK_BITS;
  localparam int IB = tkcs_pkg::IDX_BITS;

  // Input register
  logic          in_valid;
  logic [CB-1:0] in_count;
  logic [WB-1:0] in_word;
  logic          in_last;

  // Working list and drain buffer
  tkcs_pkg::slot_list_t list;
  tkcs_pkg::slot_list_t list_ins;
  tkcs_pkg::slot_list_t drain;
  logic                 busy;
  logic [IB-1:0]        rank_cnt;

  logic                 beat_out;
  logic                 drain_done;
  logic                 proceed;
  logic [tkcs_pkg::TOP_K-1:0] valid_vec;

  tkcs_insert u_insert (
    .list_cur    (list),
    .entry_count (in_count),
    .word_id     (in_word),
    .list_next   (list_ins)
  );

  assign beat_out   = m_tvalid && m_tready;
  assign drain_done = beat_out && (rank_cnt == IB'(tkcs_pkg::TOP_K - 1));
  // A last-marked entry needs the drain buffer free (or freeing this cycle)
  assign proceed    = in_valid && (!in_last || !busy || drain_done);
  assign s_tready   = !in_valid || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_count <= s_tdata[CB-1:0];
      in_word  <= s_tdata[CB+WB-1:CB];
      in_last  <= s_tlast;
    end
  end

  // List update: insert, or insert-then-clear on a last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tkcs_pkg::TOP_K; i++) begin
        list[i].valid <= 1'b0;
      end
    end else if (proceed) begin
      if (in_last) begin
        for (int i = 0; i < tkcs_pkg::TOP_K; i++) begin
          list[i].valid <= 1'b0;
        end
      end else begin
        list <= list_ins;
      end
    end
  end

  // Drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rank_cnt <= '0;
    end else if (proceed && in_last) begin
      busy     <= 1'b1;
      rank_cnt <= '0;
    end else if (beat_out) begin
      if (drain_done) begin
        busy <= 1'b0;
      end
      rank_cnt <= rank_cnt + 1'b1;
    end
  end

  // Drain buffer: loaded with the final list, empty ranks forced to zero, then
  // shifted one rank per beat so the head is always the beat on the bus.
  always_ff @(posedge clk) begin
    if (proceed && in_last) begin
      for (int i = 0; i < tkcs_pkg::TOP_K; i++) begin
        drain[i].valid   <= list_ins[i].valid;
        drain[i].count   <= list_ins[i].valid ? list_ins[i].count : '0;
        drain[i].word_id <= list_ins[i].valid ? list_ins[i].word_id : '0;
      end
    end else if (beat_out) begin
      for (int i = 0; i < tkcs_pkg::TOP_K - 1; i++) begin
        drain[i] <= drain[i+1];
      end
      drain[tkcs_pkg::TOP_K-1] <= '0;
    end
  end

  assign m_tvalid = busy;
  assign m_tuser  = drain[0].valid;
  assign m_tlast  = (rank_cnt == IB'(tkcs_pkg::TOP_K - 1));

  always_comb begin
    logic [RB-1:0] rank_field;
    rank_field = '0;
    rank_field = RB'({{RB{1'b0}}, rank_cnt});
    m_tdata = '0;
    m_tdata[RB-1:0]         = rank_field;
    m_tdata[RB+CB-1:RB]     = drain[0].count;
    m_tdata[RB+CB+WB-1:RB+CB] = drain[0].word_id;
  end

  always_comb begin
    for (int i = 0; i < tkcs_pkg::TOP_K; i++) begin
      valid_vec[i] = list[i].valid;
    end
  end

  // Valid slots always form a prefix of the ranks
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("kept slots not a prefix");

  // A last entry starts a fresh drain at rank 0
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    (proceed && in_last) |=> (m_tvalid && rank_cnt == '0))
    else $error("drain did not start at rank 0");

  // The list is empty after a last entry
  a_list_cleared: assert property (@(posedge clk) disable iff (rst)
    (proceed && in_last) |=> (valid_vec == '0))
    else $error("list not cleared after last entry");

  // Rank counter stays within the list while draining
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rank_cnt <= IB'(tkcs_pkg::TOP_K - 1)))
    else $error("rank counter out of range");

endmodule
